// ===== rtl/bmhq_pkg.sv =====
// Package for the binary max-heap queue unit: depth, widths, codes and
// transaction payload types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

	localparam int DEPTH = 1024;               // heap entries
	localparam int AW    = $clog2(DEPTH);      // memory address width
	localparam int CW    = $clog2(DEPTH + 1);  // element count / position width
	localparam int DW    = 32;                 // stored value width

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_ISSUE,
		S_UP_CMP,
		S_POP_LOAD,
		S_DN_ISSUE,
		S_DN_CMP,
		S_FINISH
	} state_t;

	typedef struct packed {
		op_t                  opcode;
		logic signed [DW-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] popped_value;
		status_t              status;
		logic [CW-1:0]        element_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/binary_max_heap_queue_unit.sv =====
// Binary max-heap priority queue of signed 32-bit values.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Max-heap priority queue. A request transaction either inserts req.value
// (opcode OP_INSERT) or pops the largest element (OP_POP); each request
// produces exactly one response transaction carrying the popped value (0
// unless a pop succeeded), a status (ok, full insert refused, empty pop
// refused) and the element count after the operation. Inserts are refused
// once the count reaches min(capacity, DEPTH); a capacity written below the
// current fill keeps the stored elements. The heap lives in one memory with
// one write port and two registered read ports. An insert climbs one level
// per pass through S_UP_ISSUE and S_UP_CMP; a pop loads the root and the
// last element in S_POP_LOAD, then sinks one level per pass through
// S_DN_ISSUE and S_DN_CMP. The pace is set by the read-compare-write loop
// on the heap memory: each level needs one registered read and one write.
// Refused operations go straight to S_FINISH. One request is worked at a
// time; a new request is taken while the previous response still waits in
// the output register. The memory has no reset and needs no clearing pass:
// only entries below the count are ever used. cfg_wdata is the capacity
// and may be written only while idle.
module binary_max_heap_queue_unit
	import bmhq_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	// request channel
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire req_t          req,
	// response channel
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output rsp_t               rsp,
	// capacity register
	input  wire logic          cfg_we,
	input  wire logic [CW-1:0] cfg_wdata
);

	// heap memory: position p (one-based) lives at address p-1
	logic signed [DW-1:0] mem [DEPTH];
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic signed [DW-1:0] mem_wd;
	logic [AW-1:0]        ra0, ra1;
	logic signed [DW-1:0] rd0_q, rd1_q;

	// control state
	state_t        state_q, state_d;
	logic [CW-1:0] cap_q;
	logic [CW-1:0] count_q, count_d;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// working registers of the current transaction
	logic [CW-1:0]        pos_q, pos_d;        // current heap position
	logic signed [DW-1:0] key_q, key_d;        // element being sifted
	logic signed [DW-1:0] popped_q, popped_d;
	status_t              status_q, status_d;
	logic                 right_ok_q, right_ok_d;  // right child exists

	logic          req_fire;
	logic [CW-1:0] bound;
	logic [CW:0]   child;       // 2*pos, one bit wider
	logic [CW:0]   n_ext;
	logic          take_right;
	logic signed [DW-1:0] child_val;
	logic          rsp_load;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid & req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign bound      = (cap_q < CW'(DEPTH)) ? cap_q : CW'(DEPTH);
	assign child      = {pos_q, 1'b0};
	assign n_ext      = {1'b0, count_q};
	assign take_right = right_ok_q && (rd0_q < rd1_q);   // left wins ties
	assign child_val  = take_right ? rd1_q : rd0_q;
	assign rsp_load   = (state_q == S_FINISH) && (!rsp_valid_q || rsp_ready);

	// memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	// Sequencer. Reads are issued in the *_ISSUE states and consumed in the next
	// cycle in the *_CMP states; every write targets the position being
	// vacated, which is never the address read in the same step, so no
	// forwarding is needed.
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		pos_d      = pos_q;
		key_d      = key_q;
		popped_d   = popped_q;
		status_d   = status_q;
		right_ok_d = right_ok_q;
		mem_we     = 1'b0;
		mem_wa     = AW'(pos_q - CW'(1));
		mem_wd     = key_q;
		ra0        = '0;
		ra1        = AW'(count_q - CW'(1));

		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					popped_d = '0;
					status_d = ST_OK;
					key_d    = req.value;
					if (req.opcode == OP_INSERT) begin
						if (count_q >= bound) begin
							status_d = ST_FULL;
							state_d  = S_FINISH;
						end else begin
							count_d = count_q + CW'(1);
							pos_d   = count_q + CW'(1);
							state_d = S_UP_ISSUE;
						end
					end else begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_FINISH;
						end else begin
							// root on port 0, last element on port 1
							state_d = S_POP_LOAD;
						end
					end
				end
			end

			S_UP_ISSUE: begin
				if (pos_q == CW'(1)) begin
					mem_we  = 1'b1;
					state_d = S_FINISH;
				end else begin
					ra0     = AW'((pos_q >> 1) - CW'(1));
					state_d = S_UP_CMP;
				end
			end

			S_UP_CMP: begin
				mem_we = 1'b1;
				if (rd0_q < key_q) begin
					// parent moves down, key keeps climbing
					mem_wd  = rd0_q;
					pos_d   = pos_q >> 1;
					state_d = S_UP_ISSUE;
				end else begin
					state_d = S_FINISH;
				end
			end

			S_POP_LOAD: begin
				popped_d = rd0_q;
				key_d    = rd1_q;
				count_d  = count_q - CW'(1);
				pos_d    = CW'(1);
				state_d  = S_DN_ISSUE;
			end

			S_DN_ISSUE: begin
				if (child > n_ext) begin
					mem_we  = 1'b1;
					state_d = S_FINISH;
				end else begin
					ra0        = AW'(child - (CW + 1)'(1));
					ra1        = AW'(child);
					right_ok_d = (child < n_ext);
					state_d    = S_DN_CMP;
				end
			end

			S_DN_CMP: begin
				mem_we = 1'b1;
				if (key_q >= child_val) begin
					state_d = S_FINISH;
				end else begin
					// larger child moves up, key keeps sinking
					mem_wd  = child_val;
					pos_d   = CW'({pos_q, take_right});
					state_d = S_DN_ISSUE;
				end
			end

			S_FINISH: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cap_q       <= CW'(DEPTH);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		key_q      <= key_d;
		popped_q   <= popped_d;
		status_q   <= status_d;
		right_ok_q <= right_ok_d;
		if (rsp_load) begin
			rsp_q.popped_value  <= popped_q;
			rsp_q.status        <= status_q;
			rsp_q.element_count <= count_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bmhq_checker.sv =====
// Port-level checker for binary_max_heap_queue_unit, with its bind.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_checker
	import bmhq_pkg::*;
(
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire rsp_t          rsp
);

	// a taken request leaves the unit busy in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one still in work");

	// refused pop: empty heap, nothing returned
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |->
			rsp.popped_value == '0 && rsp.element_count == '0)
		else $error("empty status with data or nonzero count");

	// refused insert returns no data
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.popped_value == '0)
		else $error("full status with popped data");

	// count never exceeds the memory depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.element_count <= CW'(DEPTH))
		else $error("element count beyond depth");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind binary_max_heap_queue_unit bmhq_checker u_bmhq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

// ===== sim/bmhq_checker.sv =====
// Checker for the binary max-heap queue unit: tracks capacity writes, predicts
// each response from its own heap copy and compares. Depends on bmhq_pkg.
`timescale 1ns / 1ps

module bmhq_tb_checker
	import bmhq_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_ready,
	input  wire req_t          req,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_ready,
	input  wire rsp_t          rsp,
	input  wire logic          cfg_we,
	input  wire logic [CW-1:0] cfg_wdata,
	output int                 mismatches,
	output int                 outstanding
);

	logic signed [DW-1:0] heap_mem [1:DEPTH];
	int                   heap_fill;
	logic [CW-1:0]        cap_reg;
	rsp_t                 awaited_rsp_q [$];
	int                   fail_tally = 0;
	int                   pend_tally = 0;

	assign mismatches  = fail_tally;
	assign outstanding = pend_tally;

	// Apply one operation to the shadow heap and return the response it yields.
	function automatic rsp_t heap_apply(req_t op_txn);
		rsp_t                 res;
		int                   bound;
		int                   pos;
		int                   child;
		logic signed [DW-1:0] key;
		res   = '{popped_value: '0, status: ST_OK, element_count: '0};
		bound = (cap_reg < DEPTH) ? int'(cap_reg) : DEPTH;
		if (op_txn.opcode == OP_INSERT) begin
			if (heap_fill >= bound) begin
				res.status = ST_FULL;
			end else begin
				heap_fill++;
				key = op_txn.value;
				pos = heap_fill;
				// climb past strictly smaller parents
				while (pos > 1 && heap_mem[pos / 2] < key) begin
					heap_mem[pos] = heap_mem[pos / 2];
					pos = pos / 2;
				end
				heap_mem[pos] = key;
			end
		end else begin
			if (heap_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.popped_value = heap_mem[1];
				heap_mem[1] = heap_mem[heap_fill];
				heap_fill--;
				key = heap_mem[1];
				pos = 1;
				// sink below larger children; left child wins ties
				while (2 * pos <= heap_fill) begin
					child = 2 * pos;
					if (child + 1 <= heap_fill && heap_mem[child] < heap_mem[child + 1])
						child++;
					if (key >= heap_mem[child])
						break;
					heap_mem[pos] = heap_mem[child];
					pos = child;
				end
				heap_mem[pos] = key;
			end
		end
		res.element_count = heap_fill[CW-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_tally++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			heap_fill = 0;
			cap_reg   = CW'(DEPTH);
			awaited_rsp_q.delete();
		end else begin
			if (cfg_we)
				cap_reg = cfg_wdata;
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp_q.size() == 0) begin
					report_mismatch("response with nothing pending", rsp.element_count, 0);
				end else begin
					want = awaited_rsp_q.pop_front();
					if (rsp.popped_value !== want.popped_value)
						report_mismatch("popped_value", rsp.popped_value, want.popped_value);
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.element_count !== want.element_count)
						report_mismatch("element_count", rsp.element_count, want.element_count);
				end
			end
			if (req_valid && req_ready)
				awaited_rsp_q.push_back(heap_apply(req));
		end
		pend_tally = awaited_rsp_q.size();
	end

endmodule

// ===== sim/binary_max_heap_queue_unit_tb.sv =====
// Testbench top for the binary max-heap queue unit: clock, reset, stimulus and
// verdict. Depends on bmhq_pkg, binary_max_heap_queue_unit and bmhq_tb_checker.
`timescale 1ns / 1ps

module binary_max_heap_queue_unit_tb
	import bmhq_pkg::*;
();

	localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [CW-1:0]        CAP_ALL_ONES = '1;   // beyond DEPTH: bound clamps
	localparam int                   DRAIN_CYCLES = 30;   // above the worst op latency
	localparam int                   LONG_HOLD    = 400;  // receiver hold-off, cycles

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	req_t          req       = '0;
	logic          rsp_ready = 1'b0;
	logic          cfg_we    = 1'b0;
	logic [CW-1:0] cfg_wdata = '0;
	logic          req_ready;
	logic          rsp_valid;
	rsp_t          rsp;
	int            mismatches;
	int            outstanding;

	// quiet: no idling on either side; hold_pending: asks the receiver for a long stall
	bit quiet        = 1'b0;
	bit hold_pending = 1'b0;

	binary_max_heap_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	bmhq_tb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Gap length in cycles: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Values: full-range random, plus a cluster near zero so ties show up
	// in the sift compares, plus the extremes.
	function automatic logic signed [DW-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return $urandom_range(8) - 4;
		if (r < 28) begin
			case ($urandom_range(3))
				0:       return VAL_MAX;
				1:       return VAL_MIN;
				2:       return '0;
				default: return '1;
			endcase
		end
		return $urandom();
	endfunction

	// One request transaction. Called at a falling edge; returns at a falling
	// edge after acceptance and the gap that follows. With no gap, valid just
	// stays high into the next transaction.
	task automatic send_op(input op_t op, input logic signed [DW-1:0] val);
		int gap;
		req_valid <= 1'b1;
		req       <= '{opcode: op, value: val};
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Capacity change: only with the block idle, i.e. every response back
	// and enough cycles for the last operation to retire.
	task automatic write_capacity(input logic [CW-1:0] cap);
		req_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wdata <= cap;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random mix of inserts and pops; pop payloads carry random junk.
	task automatic run_mix(input int n_txn, input int insert_pct);
		for (int i = 0; i < n_txn; i++)
			send_op(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP, pick_value());
	endtask

	// Response side: random ready runs and stalls, always ready while quiet,
	// one long hold-off on request.
	initial begin
		int hold;
		@(negedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ready <= 1'b0;
				hold = LONG_HOLD;
			end else if (quiet) begin
				rsp_ready <= 1'b1;
				hold = 1;
			end else if ($urandom_range(99) < 60) begin
				rsp_ready <= 1'b1;
				hold = $urandom_range(8, 1);
			end else begin
				rsp_ready <= 1'b0;
				hold = pick_gap();
				if (hold == 0)
					hold = 1;
			end
			repeat (hold) @(negedge clk);
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// pop on an empty heap, then extremes, a duplicate, -1 and 0
		send_op(OP_POP, VAL_MAX);
		send_op(OP_INSERT, 5);
		send_op(OP_INSERT, VAL_MAX);
		send_op(OP_INSERT, VAL_MIN);
		send_op(OP_INSERT, 5);
		send_op(OP_INSERT, -1);
		send_op(OP_INSERT, 0);
		// drain in order, then one pop too many
		repeat (7) send_op(OP_POP, '0);

		// zero capacity refuses every insert
		write_capacity('0);
		send_op(OP_INSERT, 7);
		send_op(OP_POP, '1);

		// fill to a small bound, then overflow it
		write_capacity(2);
		send_op(OP_INSERT, -3);
		send_op(OP_INSERT, 9);
		send_op(OP_INSERT, 1);

		// bound lowered below the fill: inserts refused, pops still work
		write_capacity(1);
		send_op(OP_INSERT, 4);
		send_op(OP_POP, '0);
		send_op(OP_POP, '0);
		send_op(OP_POP, '0);

		// --- random ---
		// tiny bounds: full and empty refusals all the time
		write_capacity(CAP_ALL_ONES);
		for (int p = 0; p < 4; p++) begin
			write_capacity(p == 0 ? CW'(1) : p == 1 ? CW'(2) : CW'($urandom_range(8, 3)));
			run_mix(60, 50);
		end

		// moderate bound, first half with no idling anywhere
		write_capacity(40);
		quiet = 1'b1;
		run_mix(75, 60);
		quiet = 1'b0;
		run_mix(75, 55);

		// full depth: inserts only, enough to hit DEPTH and get refused;
		// partway through the receiver stalls long so the block backs up
		write_capacity(CW'(DEPTH));
		run_mix(300, 100);
		hold_pending = 1'b1;
		run_mix(740, 100);

		// out-of-range bound clamps to DEPTH
		write_capacity(CAP_ALL_ONES);
		run_mix(100, 60);

		// bound just under DEPTH with a full heap
		write_capacity(CW'(DEPTH - 1));
		run_mix(80, 50);

		write_capacity('0);
		run_mix(30, 50);

		// wind down: all responses back, then a margin for stray ones
		req_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
